// ===== hw/rtl/rmsn_pkg.sv =====
`default_nettype none
package rmsn_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_FEATURE_COUNT = 2'd0;
  localparam logic [1:0] REG_INV_COUNT     = 2'd1;
  localparam logic [1:0] REG_EPSILON       = 2'd2;
  localparam logic [1:0] REG_OUTPUT_SCALE  = 2'd3;

  localparam logic [6:0]  FEATURE_COUNT_RST = 7'd64;
  localparam logic [15:0] INV_COUNT_RST     = 16'd1024;
  localparam logic [7:0]  EPSILON_RST       = 8'd1;
  localparam logic [15:0] OUTPUT_SCALE_RST  = 16'd256;

  // 2^40 / mean gives a 41 bit quotient, its root has 21 bits
  localparam int QUO_W      = 41;
  localparam int ROOT_W     = 21;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int ITER_W     = 6;
  localparam int RS_W       = 20;
  localparam logic [RS_W-1:0] RSQRT_MAX = 20'hFFFFF;

  typedef struct packed {
    logic load;
    logic mean;
    logic div_step;
    logic sqrt_step;
    logic sat;
    logic mul1;
    logic mul2;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic row_done;
    logic div_last;
    logic sqrt_last;
    logic idx_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rms_norm_int8_row.sv =====
`default_nettype none
// sequence: a row of n codes is taken at one code per cycle, then the mean is formed,
// a restoring divide and a square root run, and the root is saturated; then each
// result code takes a ram read, two multiplies and an output state, which holds
// while out_tready is low
// throughput is set by the shared divide/root unit and the single ram read port;
// no input is taken from the end of a row's load until its last result is emitted
// reset: rst_n synchronous active low, registers to defaults, row state cleared
module rms_norm_int8_row #(
  parameter int FEATURE_MAX = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_addr,
  input  wire [15:0] cfg_wdata,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [7:0]  in_tdata,   // [7:0] code
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [7:0] norm_code
  output logic       out_tlast   // row_last
);
  import rmsn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller sequences load, rsqrt and emit phases
  rmsn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath holds row store, sums, divider, root and requant multipliers
  rmsn_dp #(.FEATURE_MAX(FEATURE_MAX)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .code      (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .norm_code (out_tdata),
    .row_last  (out_tlast)
  );

`ifndef SYNTHESIS
  // load and emit phases never overlap
  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output active together");

  // a request that completes the row stops further input
  a_row_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && sts.row_done) |=> !in_tready)
    else $error("input still open after row completed");

  // after the last result the block is ready for a new row
  a_row_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("block not back in load after last result");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/rmsn_ram.sv =====
`default_nettype none
module rmsn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                           clk,
  input  wire                           we,
  input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire [WIDTH-1:0]               wdata,
  input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rmsn_ctrl.sv =====
`default_nettype none
module rmsn_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire             out_tready,
  input  rmsn_pkg::sts_t  sts,
  output rmsn_pkg::cmd_t  cmd
);
  import rmsn_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_MEAN = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_SAT  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_M2   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid && sts.row_done) state_nxt = S_MEAN;
      end
      S_MEAN: begin
        cmd.mean  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.emit_done = 1'b1;
          state_nxt = sts.idx_last ? S_LOAD : S_RD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rmsn_dp.sv =====
`default_nettype none
module rmsn_dp #(
  parameter int FEATURE_MAX = 64
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             cfg_we,
  input  wire [1:0]       cfg_addr,
  input  wire [15:0]      cfg_wdata,
  input  wire [7:0]       code,
  input  rmsn_pkg::cmd_t  cmd,
  output rmsn_pkg::sts_t  sts,
  output logic [7:0]      norm_code,
  output logic            row_last
);
  import rmsn_pkg::*;

  localparam int CNT_W  = $clog2(FEATURE_MAX + 1);
  localparam int AW     = $clog2(FEATURE_MAX > 1 ? FEATURE_MAX : 2);
  localparam int SUM_W  = 15 + $clog2(FEATURE_MAX > 1 ? FEATURE_MAX : 2);
  localparam int PROD_W = SUM_W + 16;
  localparam int MEAN_W = PROD_W - 8 + 1;
  localparam int LW     = CNT_W > 7 ? CNT_W : 7;

  logic [6:0]  fc_r;
  logic [15:0] inv_r, scale_r;
  logic [7:0]  eps_r;

  logic [CNT_W-1:0]  fill_r, idx_r, row_len;
  logic [LW-1:0]     len_w;
  logic [SUM_W-1:0]  sum_r;
  logic [MEAN_W-1:0] mean_r;
  logic [MEAN_W:0]   rem_r, rem_sh;
  logic [QUO_W:0]    x_r;
  logic [ITER_W-1:0] it_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W+2:0] srem_r, srem_sh, trial;
  logic [RS_W-1:0]   rs_r;
  logic              neg_r, div_ge, sq_ge;
  logic [27:0]       p1_r;
  logic [43:0]       p2_r;
  logic [44:0]       rnd;
  logic [20:0]       q;
  logic [15:0]       sq;
  logic [PROD_W-1:0] prod;
  logic [7:0]        rd_code, mag;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r    <= FEATURE_COUNT_RST;
      inv_r   <= INV_COUNT_RST;
      eps_r   <= EPSILON_RST;
      scale_r <= OUTPUT_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FEATURE_COUNT: fc_r    <= cfg_wdata[6:0];
        REG_INV_COUNT:     inv_r   <= cfg_wdata;
        REG_EPSILON:       eps_r   <= cfg_wdata[7:0];
        REG_OUTPUT_SCALE:  scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // row length clamped to 1..FEATURE_MAX
  always_comb begin
    len_w = LW'(fc_r);
    if (fc_r == 7'd0) len_w = LW'(1);
    if (len_w > LW'(FEATURE_MAX)) len_w = LW'(FEATURE_MAX);
    row_len = len_w[CNT_W-1:0];
  end

  // square of the sign-extended code, at most 2^14
  assign sq            = $signed({{8{code[7]}}, code}) * $signed({{8{code[7]}}, code});
  assign sts.row_done  = ({1'b0, fill_r} + 1'b1) >= {1'b0, row_len};
  assign sts.idx_last  = ({1'b0, idx_r} + 1'b1) == {1'b0, fill_r};
  assign sts.div_last  = it_r == ITER_W'(DIV_STEPS - 1);
  assign sts.sqrt_last = it_r == ITER_W'(SQRT_STEPS - 1);

  rmsn_ram #(.WIDTH(8), .DEPTH(FEATURE_MAX)) u_row_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (fill_r[AW-1:0]),
    .wdata (code),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_code)
  );

  assign prod    = sum_r * inv_r;
  assign rem_sh  = {rem_r[MEAN_W-1:0], x_r[QUO_W-1]};
  assign div_ge  = rem_sh >= {1'b0, mean_r};
  assign srem_sh = {srem_r[ROOT_W:0], x_r[QUO_W:QUO_W-1]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign sq_ge   = srem_sh >= trial;
  assign mag     = rd_code[7] ? 8'(-rd_code) : rd_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
      it_r   <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.load) begin
        fill_r <= fill_r + 1'b1;
        sum_r  <= sum_r + SUM_W'(sq);
      end
      if (cmd.mean) it_r <= '0;
      if (cmd.div_step) it_r <= sts.div_last ? '0 : it_r + 1'b1;
      if (cmd.sqrt_step) it_r <= it_r + 1'b1;
      if (cmd.sat) idx_r <= '0;
      if (cmd.emit_done) begin
        if (sts.idx_last) begin
          fill_r <= '0;
          sum_r  <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  // payload: mean, restoring divide, digit-by-digit root, products
  always_ff @(posedge clk) begin
    if (cmd.mean) begin
      mean_r <= MEAN_W'(prod[PROD_W-1:8]) + MEAN_W'(eps_r);
      rem_r  <= '0;
      x_r    <= {2'b01, {(QUO_W-1){1'b0}}};
      root_r <= '0;
      srem_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? rem_sh - {1'b0, mean_r} : rem_sh;
      x_r   <= {1'b0, x_r[QUO_W-2:0], div_ge};
    end
    if (cmd.sqrt_step) begin
      srem_r <= sq_ge ? srem_sh - trial : srem_sh;
      root_r <= {root_r[ROOT_W-2:0], sq_ge};
      x_r    <= {x_r[QUO_W-2:0], 2'b00};
    end
    if (cmd.sat) rs_r <= root_r[ROOT_W-1] ? RSQRT_MAX : root_r[RS_W-1:0];
    if (cmd.mul1) begin
      p1_r  <= mag * rs_r;
      neg_r <= rd_code[7];
    end
    if (cmd.mul2) p2_r <= p1_r * scale_r;
  end

  // round half away from zero on the magnitude, then saturate
  assign rnd = {1'b0, p2_r} + 45'(1 << 23);
  assign q   = rnd[44:24];
  always_comb begin
    if (neg_r) norm_code = (q > 21'd128) ? 8'h80 : 8'(-q);
    else       norm_code = (q > 21'd127) ? 8'h7F : q[7:0];
  end
  assign row_last = sts.idx_last;
endmodule
`default_nettype wire

// ===== test/tb_rms_norm_int8_row.sv =====
`default_nettype none

class norm_scoreboard;
  // shadow of the block's registers and row state
  logic [6:0]  feat_cnt;
  logic [15:0] inv_cnt;
  logic [7:0]  eps;
  logic [15:0] out_scale;
  logic signed [7:0] row_codes[64];
  longint unsigned sq_sum;
  int unsigned fill;
  logic [7:0] exp_code[$];
  bit         exp_last[$];
  int unsigned mismatches;

  function void reset_state();
    feat_cnt = rmsn_pkg::FEATURE_COUNT_RST;
    inv_cnt = rmsn_pkg::INV_COUNT_RST;
    eps = rmsn_pkg::EPSILON_RST;
    out_scale = rmsn_pkg::OUTPUT_SCALE_RST;
    sq_sum = 0;
    fill = 0;
    exp_code.delete();
    exp_last.delete();
    mismatches = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      rmsn_pkg::REG_FEATURE_COUNT: feat_cnt = val[6:0];
      rmsn_pkg::REG_INV_COUNT:     inv_cnt = val;
      rmsn_pkg::REG_EPSILON:       eps = val[7:0];
      rmsn_pkg::REG_OUTPUT_SCALE:  out_scale = val;
      default: ;
    endcase
  endfunction

  function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function logic [7:0] scale_code(logic signed [7:0] c, longint unsigned rs);
    longint unsigned mag, p, q;
    mag = (c < 0) ? -int'(c) : int'(c);
    p = mag * rs * out_scale;
    q = (p + (64'd1 << 23)) >> 24;
    if (c < 0) return (q > 128) ? 8'h80 : 8'(-longint'(q));
    return (q > 127) ? 8'h7f : 8'(q);
  endfunction

  // note an accepted code, queue the row's results when it completes
  function void note_code(logic signed [7:0] c);
    int unsigned len;
    longint unsigned mean, rs;
    if (fill < 64) begin
      row_codes[fill] = c;
      sq_sum += longint'(c) * longint'(c);
      fill++;
    end
    len = (feat_cnt == 0) ? 1 : (feat_cnt > 64 ? 64 : feat_cnt);
    if (fill < len) return;
    mean = ((sq_sum * inv_cnt) >> 8) + eps;
    if (mean == 0) rs = 20'hFFFFF;
    else begin
      rs = int_sqrt((64'd1 << 40) / mean);
      if (rs > 20'hFFFFF) rs = 20'hFFFFF;
    end
    for (int k = 0; k < fill; k++) begin
      exp_code.push_back(scale_code(row_codes[k], rs));
      exp_last.push_back(k + 1 == fill);
    end
    sq_sum = 0;
    fill = 0;
  endfunction

  function void check_result(logic [7:0] code, logic last);
    logic [7:0] ec;
    bit el;
    if (exp_code.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result code=%0h last=%0b", code, last);
      return;
    end
    ec = exp_code.pop_front();
    el = exp_last.pop_front();
    if (code !== ec || last !== el) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected code=%0h last=%0b, got code=%0h last=%0b",
                 ec, el, code, last);
    end
  endfunction
endclass

module tb_rms_norm_int8_row;
  timeunit 1ns;
  timeprecision 1ps;
  import rmsn_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] code
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] norm_code
  logic        out_tlast;       // row_last

  norm_scoreboard sb;
  int  send_idle_pct = 0;      // percent of cycles the sender holds back
  int  recv_stall_pct = 0;     // percent of cycles the receiver stalls
  int  hold_off_cycles = 0;    // long receiver hold-off, counted down below
  int  idle_cycles = 0;
  bit  done = 0;

  always #5 clk = ~clk;

  rms_norm_int8_row u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check every accepted result, watchdog on a stuck handshake
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one request on the input channel, with a random gap before it
  task automatic send_code(logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_code(c);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // wait for all results, then for the block's tail before touching registers
  task automatic drain();
    while (sb.exp_code.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // set the row length with a matching reciprocal, the epsilon and the output scale
  task automatic set_row(int n, logic [7:0] e, logic [15:0] s);
    write_reg(REG_FEATURE_COUNT, 16'(n));
    write_reg(REG_INV_COUNT, (n == 0) ? 16'hFFFF : 16'(65536 / n));
    write_reg(REG_EPSILON, e);
    write_reg(REG_OUTPUT_SCALE, s);
  endtask

  task automatic random_rows(int items);
    int n, sent;
    sent = 0;
    while (sent < items) begin
      drain();
      n = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 12);
      set_row(n, 8'($urandom_range(255)),
              ($urandom_range(3) == 0) ? 16'($urandom) : 16'(256 + $urandom_range(2048)));
      if ($urandom_range(4) == 0) write_reg(REG_INV_COUNT, 16'($urandom));
      for (int i = 0; i < n; i++) begin
        send_code(($urandom_range(3) == 0) ? 8'($urandom_range(8) - 4) : 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes with default epsilon and output scale, short row of 4
    set_row(4, 8'd1, 16'd256);
    send_code(8'h7f); send_code(8'h80); send_code(8'h00); send_code(8'hff);
    drain();
    // zero mean: all zero codes with no epsilon
    set_row(2, 8'd0, 16'hFFFF);
    send_code(8'h00); send_code(8'h00);
    drain();
    // small mean gives a large rsqrt, output saturates both ways
    set_row(3, 8'd0, 16'hFFFF);
    send_code(8'h01); send_code(8'hff); send_code(8'h00);
    drain();
    // zero count treated as one, above the maximum saturates to 64 (below)
    write_reg(REG_FEATURE_COUNT, 16'd0);
    send_code(8'h55);
    drain();
    write_reg(REG_OUTPUT_SCALE, 16'd0);
    send_code(8'h80);
    drain();
    // count lowered mid-row: next code completes the row
    set_row(6, 8'hff, 16'd300);
    send_code(8'h10); send_code(8'hf0); send_code(8'h22);
    write_reg(REG_FEATURE_COUNT, 16'd2);
    write_reg(REG_INV_COUNT, 16'd0);
    send_code(8'h33);
    drain();
    // full 64 via a count above the maximum, index beyond list is not possible
    write_reg(REG_FEATURE_COUNT, 16'd127);
    write_reg(REG_INV_COUNT, 16'd1024);
    for (int i = 0; i < 64; i++) send_code(8'(i * 5 - 128));
    drain();

    // random phases: none, sender idle, receiver stall, both
    random_rows(55);
    send_idle_pct = 48; random_rows(55);
    send_idle_pct = 0; recv_stall_pct = 48; random_rows(55);
    send_idle_pct = 16; recv_stall_pct = 16; random_rows(40);

    // long receiver hold-off while the sender keeps offering requests
    drain();
    send_idle_pct = 0; recv_stall_pct = 0;
    set_row(5, 8'd7, 16'd400);
    hold_off_cycles = 400;
    for (int i = 0; i < 20; i++) send_code(8'($urandom));
    // sender pauses until every result is back
    drain();
    for (int i = 0; i < 5; i++) send_code(8'($urandom));

    drain();
    done = 1;
    if (sb.mismatches == 0 && sb.exp_code.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== rms_norm_int8_row.f =====
hw/rtl/rmsn_pkg.sv
hw/rtl/rmsn_ram.sv
hw/rtl/rmsn_ctrl.sv
hw/rtl/rmsn_dp.sv
hw/rtl/rms_norm_int8_row.sv
test/tb_rms_norm_int8_row.sv
